// File: hdl/llhp_pkg.sv
`timescale 1ns / 1ps

package llhp_pkg;

    localparam int HIST_BUCKETS_DEF = 32;
    localparam int IDX_W_MAX        = 6;
    localparam int NUM_PCT          = 3;

    localparam logic [9:0] NS_PER_US = 10'd1000;
    localparam logic [6:0] PCT_SCALE = 7'd100;
    localparam logic [6:0] PCT_LIST [NUM_PCT] = '{7'd50, 7'd95, 7'd99};

    typedef struct packed {
        logic [39:0] total_time_ns;
        logic [39:0] tune_time_ns;
        logic [39:0] send_time_ns;
        logic [39:0] close_time_ns;
    } sample_t;

    typedef struct packed {
        logic [47:0] sample_count;
        logic [63:0] sum_total_ns;
        logic [63:0] sum_tune_ns;
        logic [63:0] sum_send_ns;
        logic [63:0] sum_close_ns;
        logic [63:0] sum_other_ns;
        logic [31:0] total_p50_us;
        logic [31:0] total_p95_us;
        logic [31:0] total_p99_us;
        logic [31:0] send_p50_us;
        logic [31:0] send_p95_us;
        logic [31:0] send_p99_us;
    } report_t;

    typedef struct packed {
        logic sample_take;
        logic hist_write;
        logic walk_start;
        logic walk_issue;
        logic load_report;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic report_due;
        logic walk_last;
    } sts_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // bucket index to power-of-two microseconds, top clamped at 2^31
    function automatic logic [31:0] pct_value(input logic [IDX_W_MAX-1:0] idx);
        logic [4:0] sh;
        sh = (idx > IDX_W_MAX'(31)) ? 5'd31 : idx[4:0];
        return 32'd1 << sh;
    endfunction

endpackage

// File: hdl/llhp_ram.sv
`timescale 1ns / 1ps

module llhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/llhp_dp.sv
`timescale 1ns / 1ps

module llhp_dp import llhp_pkg::*; #(
    parameter int HIST_BUCKETS = HIST_BUCKETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  sample_t     sample,
    input  cmd_t        cmd,
    output sts_t        sts,
    output report_t     report
);

    localparam int BW = $clog2(HIST_BUCKETS);
    localparam int CW = 39;
    localparam logic [BW-1:0] TOP_BKT = BW'(HIST_BUCKETS - 1);

    // floor(log2(ns/1000)) >= b exactly when ns >= 1000 * 2^b
    function automatic logic [BW-1:0] bucket_of(input logic [39:0] ns);
        logic [BW-1:0] b_sel;
        b_sel = '0;
        for (int b = 1; b < HIST_BUCKETS; b++)
        begin
            if ({40'd0, ns} >= (80'(NS_PER_US) << b))
            begin
                b_sel = BW'(b);
            end
        end
        return b_sel;
    endfunction

    logic [31:0]       report_every_reg;
    logic [47:0]       samples_seen_reg;
    logic [31:0]       window_fill_reg;
    logic [63:0]       acc_total_reg;
    logic [63:0]       acc_tune_reg;
    logic [63:0]       acc_send_reg;
    logic [63:0]       acc_close_reg;
    logic              due_reg;

    logic [BW-1:0]     tot_bkt_c;
    logic [BW-1:0]     snd_bkt_c;
    logic [BW-1:0]     tot_bkt_reg;
    logic [BW-1:0]     snd_bkt_reg;
    logic [BW-1:0]     tot_raddr;
    logic [BW-1:0]     snd_raddr;
    logic [31:0]       tot_rdata;
    logic [31:0]       snd_rdata;
    logic [31:0]       tot_cnt;
    logic [31:0]       snd_cnt;
    logic [31:0]       tot_wdata;
    logic [31:0]       snd_wdata;
    logic [HIST_BUCKETS-1:0] tot_vld_reg;
    logic [HIST_BUCKETS-1:0] snd_vld_reg;
    logic              tot_rv_reg;
    logic              snd_rv_reg;

    logic [BW-1:0]     walk_idx_reg;
    logic              p1_vld_reg;
    logic              p2_vld_reg;
    logic [BW-1:0]     p1_idx_reg;
    logic [BW-1:0]     p2_idx_reg;
    logic [CW-1:0]     tot_c100_reg;
    logic [CW-1:0]     snd_c100_reg;
    logic [CW-1:0]     tot_seen_reg;
    logic [CW-1:0]     snd_seen_reg;
    logic [CW-1:0]     tot_seen_next;
    logic [CW-1:0]     snd_seen_next;
    logic [CW-1:0]     tgt_reg [NUM_PCT];
    logic [NUM_PCT-1:0] tot_hit;
    logic [NUM_PCT-1:0] snd_hit;
    logic [NUM_PCT-1:0] tot_found_reg;
    logic [NUM_PCT-1:0] snd_found_reg;
    logic [BW-1:0]     tot_pidx_reg [NUM_PCT];
    logic [BW-1:0]     snd_pidx_reg [NUM_PCT];

    logic [63:0]       parts_a_reg;
    logic [63:0]       parts_reg;
    logic [63:0]       other_reg;
    report_t           report_reg;

    assign tot_bkt_c = bucket_of(sample.total_time_ns);
    assign snd_bkt_c = bucket_of(sample.send_time_ns);
    assign tot_raddr = cmd.walk_issue ? walk_idx_reg : tot_bkt_c;
    assign snd_raddr = cmd.walk_issue ? walk_idx_reg : snd_bkt_c;

    // entries not written since the last report read as zero
    assign tot_cnt   = tot_rv_reg ? tot_rdata : 32'd0;
    assign snd_cnt   = snd_rv_reg ? snd_rdata : 32'd0;
    assign tot_wdata = tot_cnt + 32'd1;
    assign snd_wdata = snd_cnt + 32'd1;

    llhp_ram #(
        .WIDTH (32),
        .DEPTH (HIST_BUCKETS)
    ) u_tot_ram (
        .clk   (clk),
        .we    (cmd.hist_write),
        .waddr (tot_bkt_reg),
        .wdata (tot_wdata),
        .raddr (tot_raddr),
        .rdata (tot_rdata)
    );

    llhp_ram #(
        .WIDTH (32),
        .DEPTH (HIST_BUCKETS)
    ) u_snd_ram (
        .clk   (clk),
        .we    (cmd.hist_write),
        .waddr (snd_bkt_reg),
        .wdata (snd_wdata),
        .raddr (snd_raddr),
        .rdata (snd_rdata)
    );

    // percentile test: seen >= ceil(w*p/100) is the same as 100*seen >= w*p
    always_comb
    begin
        tot_seen_next = tot_seen_reg + tot_c100_reg;
        snd_seen_next = snd_seen_reg + snd_c100_reg;
        for (int k = 0; k < NUM_PCT; k++)
        begin
            tot_hit[k] = tot_seen_next >= tgt_reg[k];
            snd_hit[k] = snd_seen_next >= tgt_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_every_reg <= '0;
            samples_seen_reg <= '0;
            window_fill_reg  <= '0;
            acc_total_reg    <= '0;
            acc_tune_reg     <= '0;
            acc_send_reg     <= '0;
            acc_close_reg    <= '0;
            due_reg          <= 1'b0;
            tot_vld_reg      <= '0;
            snd_vld_reg      <= '0;
            tot_rv_reg       <= 1'b0;
            snd_rv_reg       <= 1'b0;
            walk_idx_reg     <= '0;
            p1_vld_reg       <= 1'b0;
            p2_vld_reg       <= 1'b0;
            tot_found_reg    <= '0;
            snd_found_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                report_every_reg <= cfg_wr_data;
            end

            if (cmd.sample_take)
            begin
                samples_seen_reg <= samples_seen_reg + 48'd1;
                window_fill_reg  <= window_fill_reg + 32'd1;
                acc_total_reg    <= sat_add64(acc_total_reg, 64'(sample.total_time_ns));
                acc_tune_reg     <= sat_add64(acc_tune_reg, 64'(sample.tune_time_ns));
                acc_send_reg     <= sat_add64(acc_send_reg, 64'(sample.send_time_ns));
                acc_close_reg    <= sat_add64(acc_close_reg, 64'(sample.close_time_ns));
                due_reg <= ({1'b0, window_fill_reg} + 33'd1) >= {1'b0, report_every_reg};
            end
            else if (cmd.load_report)
            begin
                window_fill_reg <= '0;
                acc_total_reg   <= '0;
                acc_tune_reg    <= '0;
                acc_send_reg    <= '0;
                acc_close_reg   <= '0;
            end

            if (cmd.load_report)
            begin
                tot_vld_reg <= '0;
                snd_vld_reg <= '0;
            end
            else if (cmd.hist_write)
            begin
                tot_vld_reg[tot_bkt_reg] <= 1'b1;
                snd_vld_reg[snd_bkt_reg] <= 1'b1;
            end

            tot_rv_reg <= tot_vld_reg[tot_raddr];
            snd_rv_reg <= snd_vld_reg[snd_raddr];

            if (cmd.walk_start)
            begin
                walk_idx_reg <= '0;
            end
            else if (cmd.walk_issue)
            begin
                walk_idx_reg <= walk_idx_reg + BW'(1);
            end

            p1_vld_reg <= cmd.walk_issue;
            p2_vld_reg <= p1_vld_reg;

            if (cmd.walk_start)
            begin
                tot_found_reg <= '0;
                snd_found_reg <= '0;
            end
            else if (p2_vld_reg)
            begin
                tot_found_reg <= tot_found_reg | tot_hit;
                snd_found_reg <= snd_found_reg | snd_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sample_take)
        begin
            tot_bkt_reg <= tot_bkt_c;
            snd_bkt_reg <= snd_bkt_c;
        end

        p1_idx_reg   <= walk_idx_reg;
        p2_idx_reg   <= p1_idx_reg;
        tot_c100_reg <= CW'(tot_cnt) * CW'(PCT_SCALE);
        snd_c100_reg <= CW'(snd_cnt) * CW'(PCT_SCALE);

        for (int k = 0; k < NUM_PCT; k++)
        begin
            tgt_reg[k] <= CW'(window_fill_reg) * CW'(PCT_LIST[k]);
        end

        // other-time chain settles while the buckets are walked
        parts_a_reg <= sat_add64(acc_tune_reg, acc_send_reg);
        parts_reg   <= sat_add64(parts_a_reg, acc_close_reg);
        other_reg   <= (acc_total_reg > parts_reg) ? acc_total_reg - parts_reg : 64'd0;

        if (cmd.walk_start)
        begin
            tot_seen_reg <= '0;
            snd_seen_reg <= '0;
            for (int k = 0; k < NUM_PCT; k++)
            begin
                tot_pidx_reg[k] <= TOP_BKT;
                snd_pidx_reg[k] <= TOP_BKT;
            end
        end
        else if (p2_vld_reg)
        begin
            tot_seen_reg <= tot_seen_next;
            snd_seen_reg <= snd_seen_next;
            for (int k = 0; k < NUM_PCT; k++)
            begin
                if (!tot_found_reg[k] && tot_hit[k])
                begin
                    tot_pidx_reg[k] <= p2_idx_reg;
                end
                if (!snd_found_reg[k] && snd_hit[k])
                begin
                    snd_pidx_reg[k] <= p2_idx_reg;
                end
            end
        end

        if (cmd.load_report)
        begin
            report_reg.sample_count <= samples_seen_reg;
            report_reg.sum_total_ns <= acc_total_reg;
            report_reg.sum_tune_ns  <= acc_tune_reg;
            report_reg.sum_send_ns  <= acc_send_reg;
            report_reg.sum_close_ns <= acc_close_reg;
            report_reg.sum_other_ns <= other_reg;
            report_reg.total_p50_us <= pct_value(IDX_W_MAX'(tot_pidx_reg[0]));
            report_reg.total_p95_us <= pct_value(IDX_W_MAX'(tot_pidx_reg[1]));
            report_reg.total_p99_us <= pct_value(IDX_W_MAX'(tot_pidx_reg[2]));
            report_reg.send_p50_us  <= pct_value(IDX_W_MAX'(snd_pidx_reg[0]));
            report_reg.send_p95_us  <= pct_value(IDX_W_MAX'(snd_pidx_reg[1]));
            report_reg.send_p99_us  <= pct_value(IDX_W_MAX'(snd_pidx_reg[2]));
        end
    end

    assign sts.enabled    = report_every_reg != 32'd0;
    assign sts.report_due = due_reg;
    assign sts.walk_last  = walk_idx_reg == TOP_BKT;
    assign report         = report_reg;

endmodule

// File: hdl/llhp_ctrl.sv
`timescale 1ns / 1ps

module llhp_ctrl import llhp_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic sample_valid,
    output logic sample_stall,
    output logic report_valid,
    input  logic report_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_UPDATE = 6'b000010,
        S_WALK   = 6'b000100,
        S_DRAIN1 = 6'b001000,
        S_DRAIN2 = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   report_valid_reg;
    logic   report_valid_next;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                // with the block disabled a sample is taken and dropped
                if (sample_valid && sts.enabled)
                begin
                    cmd.sample_take = 1'b1;
                    state_next      = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.hist_write = 1'b1;
                if (sts.report_due)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                cmd.walk_issue = 1'b1;
                if (sts.walk_last)
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!report_valid_reg || !report_stall)
                begin
                    cmd.load_report = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        report_valid_next = report_valid_reg;
        if (cmd.load_report)
        begin
            report_valid_next = 1'b1;
        end
        else if (report_valid_reg && !report_stall)
        begin
            report_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            report_valid_reg <= report_valid_next;
        end
    end

    assign sample_stall = state_reg != S_IDLE;
    assign report_valid = report_valid_reg;

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_report |-> (!report_valid_reg || !report_stall))
        else $error("report loaded over an untaken report");

    a_due_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && sts.report_due) |=> (state_reg == S_WALK))
        else $error("window close did not start the bucket walk");

    a_walk_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && sts.walk_last) |=> (state_reg == S_DRAIN1))
        else $error("bucket walk did not stop at the top bucket");

    a_report_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_report |=> (report_valid && state_reg == S_IDLE))
        else $error("loaded report not presented");

endmodule

// File: hdl/latency_log2_histogram_profiler.sv
`timescale 1ns / 1ps

// latency profiler: one latency sample in, one report out per window.
// sample channel (sample_valid / sample_stall / sample): a transfer takes one
// sample of total, tune, send and close times in ns.
// report channel (report_valid / report_stall / report): a report carries the
// cumulative sample count, the window sums, other time and the p50/p95/p99 of
// the log2-microsecond histograms of total and send time.
// cfg_wr_en / cfg_wr_data set the window length; zero disables the block, and
// samples are then transferred and dropped. write it only while idle.
// after each sample the input stalls for the read-modify-write of the
// bucket counter in each histogram ram before the next sample is taken.
// a sample that closes a window stalls the input while the walk over the
// buckets runs, one bucket a cycle through a three-stage pipe, and until
// the report is loaded into the output register, where it is then valid.
// a finished report waits in an output register; samples keep flowing while
// the receiver stalls, until the next window closes, which then waits for
// the register to free.
// reset clears all sums, counts and histograms and sets the window to zero.
module latency_log2_histogram_profiler import llhp_pkg::*; #(
    parameter int HIST_BUCKETS = HIST_BUCKETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        report_valid,
    input  logic        report_stall,
    output report_t     report
);

    cmd_t cmd;
    sts_t sts;

    llhp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    llhp_dp #(
        .HIST_BUCKETS (HIST_BUCKETS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample),
        .cmd         (cmd),
        .sts         (sts),
        .report      (report)
    );

endmodule
